@@ hdl/pds_pkg.sv @@
// shared types, constants and helpers for the plate deflection series block
`timescale 1ns / 1ps

package pds_pkg;

  localparam int MAX_TERMS = 16;
  localparam int FRAC_BITS = 16;
  localparam int ACC_BITS  = 48;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int PQ_W  = IDX_W + 1;
  localparam int MAG_W = FRAC_BITS + 1;

  // radix-16 restoring divider on a padded dividend
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = (ACC_BITS + 1 + DIV_BITS - 1) / DIV_BITS;
  localparam int DVD_W     = DIV_STEPS * DIV_BITS;
  localparam int SUM_W     = ACC_BITS + 2;

  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  localparam logic [1:0] REG_AMPLITUDE  = 2'd0;
  localparam logic [1:0] REG_HALF_THICK = 2'd1;
  localparam logic [1:0] REG_TERM_COUNT = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PHASE, OP_ZSQ, OP_POLY, OP_SINE, OP_TMUL,
    OP_TSQ, OP_TDEN, OP_DIV, OP_TACC, OP_ABS, OP_SCALE, OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PH, ST_Z2, ST_POLY, ST_SFIN, ST_TA, ST_TB, ST_TC,
    ST_DIV, ST_TACC, ST_O1, ST_O2, ST_O3
  } state_t;

  typedef struct packed {
    dp_op_t          op;
    logic            sel_v;
    logic [IDX_W-1:0] idx;
    logic [PQ_W-1:0] p;
    logic [PQ_W-1:0] q;
    logic [1:0]      hs;
  } dp_cmd_t;

  // horner coefficient for polynomial step hs
  function automatic logic [31:0] sin_coef(input logic [1:0] hs);
    logic [31:0] c;
    case (hs)
      2'd0:    c = SIN_C7;
      2'd1:    c = SIN_C5;
      2'd2:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/pds_ctrl.sv @@
// sequencer for the plate deflection series: sines, terms and output steps
`timescale 1ns / 1ps

module pds_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [4:0]             term_count,
  output logic                   busy,
  output pds_pkg::dp_cmd_t       cmd
);

  pds_pkg::state_t state, state_next;
  logic [pds_pkg::IDX_W-1:0] m, m_next, n, n_next, last, last_next;
  logic                      phase_v, phase_v_next;
  logic [1:0]                hs, hs_next;
  logic [3:0]                dcnt, dcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pds_pkg::ST_IDLE;
      m       <= '0;
      n       <= '0;
      last    <= '0;
      phase_v <= 1'b0;
      hs      <= '0;
      dcnt    <= '0;
    end else begin
      state   <= state_next;
      m       <= m_next;
      n       <= n_next;
      last    <= last_next;
      phase_v <= phase_v_next;
      hs      <= hs_next;
      dcnt    <= dcnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    m_next       = m;
    n_next       = n;
    last_next    = last;
    phase_v_next = phase_v;
    hs_next      = hs;
    dcnt_next    = dcnt;
    cmd.op       = pds_pkg::OP_NONE;
    cmd.sel_v    = phase_v;
    cmd.idx      = n;
    cmd.p        = {m, 1'b1};
    cmd.q        = {n, 1'b1};
    cmd.hs       = hs;
    busy         = (state != pds_pkg::ST_IDLE);
    case (state)
      pds_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op = pds_pkg::OP_LOAD;
          // zero terms means one, above the maximum saturates
          if (term_count == 5'd0)
            last_next = '0;
          else if (term_count > 5'(pds_pkg::MAX_TERMS))
            last_next = pds_pkg::IDX_W'(pds_pkg::MAX_TERMS - 1);
          else
            last_next = pds_pkg::IDX_W'(term_count - 5'd1);
          m_next       = '0;
          n_next       = '0;
          phase_v_next = 1'b1;
          state_next   = pds_pkg::ST_PH;
        end
      end
      pds_pkg::ST_PH: begin
        cmd.op     = pds_pkg::OP_PHASE;
        state_next = pds_pkg::ST_Z2;
      end
      pds_pkg::ST_Z2: begin
        cmd.op     = pds_pkg::OP_ZSQ;
        hs_next    = '0;
        state_next = pds_pkg::ST_POLY;
      end
      pds_pkg::ST_POLY: begin
        cmd.op  = pds_pkg::OP_POLY;
        hs_next = hs + 2'd1;
        if (hs == 2'd3) state_next = pds_pkg::ST_SFIN;
      end
      pds_pkg::ST_SFIN: begin
        cmd.op = pds_pkg::OP_SINE;
        if (phase_v) begin
          if (n == last) begin
            n_next       = '0;
            phase_v_next = 1'b0;
          end else begin
            n_next = n + 1'b1;
          end
          state_next = pds_pkg::ST_PH;
        end else begin
          n_next     = '0;
          state_next = pds_pkg::ST_TA;
        end
      end
      pds_pkg::ST_TA: begin
        cmd.op     = pds_pkg::OP_TMUL;
        state_next = pds_pkg::ST_TB;
      end
      pds_pkg::ST_TB: begin
        cmd.op     = pds_pkg::OP_TSQ;
        state_next = pds_pkg::ST_TC;
      end
      pds_pkg::ST_TC: begin
        cmd.op     = pds_pkg::OP_TDEN;
        dcnt_next  = '0;
        state_next = pds_pkg::ST_DIV;
      end
      pds_pkg::ST_DIV: begin
        cmd.op    = pds_pkg::OP_DIV;
        dcnt_next = dcnt + 4'd1;
        if (dcnt == 4'(pds_pkg::DIV_STEPS - 1)) state_next = pds_pkg::ST_TACC;
      end
      pds_pkg::ST_TACC: begin
        cmd.op = pds_pkg::OP_TACC;
        if (n == last) begin
          n_next = '0;
          if (m == last) begin
            state_next = pds_pkg::ST_O1;
          end else begin
            m_next     = m + 1'b1;
            state_next = pds_pkg::ST_PH;
          end
        end else begin
          n_next     = n + 1'b1;
          state_next = pds_pkg::ST_TA;
        end
      end
      pds_pkg::ST_O1: begin
        cmd.op     = pds_pkg::OP_ABS;
        state_next = pds_pkg::ST_O2;
      end
      pds_pkg::ST_O2: begin
        cmd.op     = pds_pkg::OP_SCALE;
        state_next = pds_pkg::ST_O3;
      end
      pds_pkg::ST_O3: begin
        cmd.op     = pds_pkg::OP_OUT;
        state_next = pds_pkg::ST_IDLE;
      end
      default: state_next = pds_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hdl/pds_dp.sv @@
// datapath: sine polynomial, term divider, series accumulator and output scaling
`timescale 1ns / 1ps

module pds_dp (
  input  logic                clk,
  input  logic                rst,
  input  pds_pkg::dp_cmd_t    cmd,
  input  logic [15:0]         u_pos,
  input  logic [15:0]         v_pos,
  input  logic [31:0]         amplitude,
  input  logic [31:0]         half_thickness,
  output logic                done,
  output logic signed [33:0]  deflection
);

  localparam int MAG_W = pds_pkg::MAG_W;
  localparam int DVD_W = pds_pkg::DVD_W;
  localparam int SUM_W = pds_pkg::SUM_W;
  localparam int RND_SH = 30 - pds_pkg::FRAC_BITS;
  localparam int NUM_SH = pds_pkg::ACC_BITS - 2 * pds_pkg::FRAC_BITS;
  localparam int SS_W   = 2 * pds_pkg::PQ_W + 1;

  logic [15:0]      u_r, v_r;
  logic [30:0]      z, z2;
  logic [31:0]      acc;
  logic             sneg;
  logic [MAG_W-1:0] sp_mag;
  logic             sp_neg;
  logic [MAG_W-1:0] sq_mag [pds_pkg::MAX_TERMS];
  logic             sq_neg [pds_pkg::MAX_TERMS];
  logic [DVD_W-1:0] dvd;
  logic [32:0]      rem;
  logic [2*pds_pkg::PQ_W-1:0] pq;
  logic [2*pds_pkg::PQ_W:0]   ss;
  logic [31:0]      ss2;
  logic [31:0]      den;
  logic             tneg;
  logic signed [SUM_W-1:0] sum;
  logic             oneg;
  logic [32:0]      magc;
  logic [32:0]      prod;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      pds_pkg::OP_ZSQ:   begin mul_a = {1'b0, z};  mul_b = {1'b0, z}; end
      pds_pkg::OP_POLY:  begin mul_a = {1'b0, z2}; mul_b = acc;       end
      pds_pkg::OP_SINE:  begin mul_a = {1'b0, z};  mul_b = acc;       end
      pds_pkg::OP_TMUL:  begin
        mul_a = 32'(sp_mag);
        mul_b = 32'(sq_mag[cmd.idx]);
      end
      pds_pkg::OP_SCALE: begin mul_a = magc[31:0]; mul_b = amplitude; end
      default: ;
    endcase
    mul = 64'(mul_a) * 64'(mul_b);
  end

  // phase fold
  logic [pds_pkg::PQ_W+15:0] ph_full;
  logic [16:0] ph_r;
  always_comb begin
    ph_full = (pds_pkg::PQ_W+16)'(cmd.sel_v ? cmd.q : cmd.p) *
              (pds_pkg::PQ_W+16)'(cmd.sel_v ? v_r : u_r);
    ph_r = {1'b0, ph_full[15:0]};
    if (ph_r > 17'd32768) ph_r = 17'd65536 - ph_r;
  end

  // sine finish: clamp then round
  logic [33:0]      s_raw;
  logic [MAG_W-1:0] s_rnd;
  always_comb begin
    s_raw = mul[63:30];
    if (s_raw > 34'(1 << 30)) s_raw = 34'(1 << 30);
    s_rnd = MAG_W'((s_raw + 34'(1 << (RND_SH - 1))) >> RND_SH);
  end

  // four quotient bits a cycle
  logic [32:0]      dv_r;
  logic [DVD_W-1:0] dv_d;
  always_comb begin
    dv_r = rem;
    dv_d = dvd;
    for (int i = 0; i < pds_pkg::DIV_BITS; i++) begin
      dv_r = {dv_r[31:0], dv_d[DVD_W-1]};
      dv_d = {dv_d[DVD_W-2:0], 1'b0};
      if (dv_r >= {1'b0, den}) begin
        dv_r    = dv_r - {1'b0, den};
        dv_d[0] = 1'b1;
      end
    end
  end

  logic signed [SUM_W-1:0] quo;
  logic [SUM_W-1:0]        sum_abs;
  logic [SUM_W-16:0]       rnd;
  logic [63:0]             scaled;
  logic signed [36:0]      res;
  assign quo     = SUM_W'(dvd);
  assign sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign rnd     = (SUM_W-15)'((sum_abs + SUM_W'(1 << 15)) >> 16);
  assign scaled  = mul + (64'd1 << 31);

  always_comb begin
    res = oneg ? -$signed({4'b0, prod}) : $signed({4'b0, prod});
    res = res + $signed({5'b0, half_thickness});
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (cmd.op == pds_pkg::OP_OUT);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pds_pkg::OP_LOAD: begin
        u_r <= u_pos;
        v_r <= v_pos;
        sum <= '0;
      end
      pds_pkg::OP_PHASE: begin
        z    <= 31'(ph_r) << 15;
        sneg <= ph_full[16];
      end
      pds_pkg::OP_ZSQ: begin
        z2  <= mul[60:30];
        acc <= pds_pkg::SIN_C9;
      end
      pds_pkg::OP_POLY: acc <= pds_pkg::sin_coef(cmd.hs) - mul[61:30];
      pds_pkg::OP_SINE: begin
        if (cmd.sel_v) begin
          sq_mag[cmd.idx] <= s_rnd;
          sq_neg[cmd.idx] <= sneg && (s_rnd != '0);
        end else begin
          sp_mag <= s_rnd;
          sp_neg <= sneg && (s_rnd != '0);
        end
      end
      pds_pkg::OP_TMUL: begin
        dvd  <= DVD_W'(mul[2*MAG_W-1:0]) << NUM_SH;
        pq   <= (2*pds_pkg::PQ_W)'(cmd.p) * (2*pds_pkg::PQ_W)'(cmd.q);
        ss   <= SS_W'(cmd.p) * SS_W'(cmd.p) + SS_W'(cmd.q) * SS_W'(cmd.q);
        tneg <= sp_neg ^ sq_neg[cmd.idx];
      end
      pds_pkg::OP_TSQ: ss2 <= 32'(ss) * 32'(ss);
      pds_pkg::OP_TDEN: begin
        den <= 32'(pq) * ss2;
        rem <= '0;
      end
      pds_pkg::OP_DIV: begin
        rem <= dv_r;
        dvd <= dv_d;
      end
      pds_pkg::OP_TACC: sum <= tneg ? sum - quo : sum + quo;
      pds_pkg::OP_ABS: begin
        oneg <= sum[SUM_W-1];
        magc <= (rnd > (SUM_W-15)'(64'd1 << 32)) ? 33'(64'd1 << 32) : 33'(rnd);
      end
      pds_pkg::OP_SCALE: prod <= magc[32] ? {1'b0, amplitude} : {1'b0, scaled[63:32]};
      pds_pkg::OP_OUT: begin
        if (res > 37'sd8589934591)       deflection <= 34'sh1FFFFFFFF;
        else if (res < -37'sd8589934592) deflection <= 34'sh200000000;
        else                             deflection <= res[33:0];
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/plate_deflection_series.sv @@
// top level: configuration registers, sequencer and datapath of the plate series
`timescale 1ns / 1ps

// Deflection of a square, simply supported plate under uniform pressure at one
// point, from the Navier double sine series over odd harmonics. Pulse start
// while busy is low with u_pos and v_pos (Q0.16 fractions of the side); one
// result beat follows as a single-cycle done strobe with deflection, and the
// receiver cannot stall it, so capture it in that cycle. With T the effective
// term count (1..16), each of the T*T terms runs through one pass of the
// shared multiplier plus a radix-16 restoring divider, and each of the 2*T
// sines runs a seven-step Horner sequence on the same multiplier. The user
// must write registers through wr_en / wr_index / wr_data only while busy
// is low; the block itself does not enforce it. An unknown index is ignored.
module plate_deflection_series (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        u_pos,
  input  logic [15:0]        v_pos,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  output logic               done,
  output logic signed [33:0] deflection
);

  // configuration registers
  logic [31:0] amplitude;
  logic [31:0] half_thickness;
  logic [4:0]  term_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude      <= '0;
      half_thickness <= '0;
      term_count     <= 5'd8;
    end else if (wr_en) begin
      case (wr_index)
        pds_pkg::REG_AMPLITUDE:  amplitude      <= wr_data;
        pds_pkg::REG_HALF_THICK: half_thickness <= wr_data;
        pds_pkg::REG_TERM_COUNT: term_count     <= wr_data[4:0];
        default: ;
      endcase
    end
  end

  pds_pkg::dp_cmd_t cmd;

  // sequencer walks v sines, then for each row a u sine and its terms
  pds_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .term_count (term_count),
    .busy       (busy),
    .cmd        (cmd)
  );

  // arithmetic, sine table of the v axis, accumulator and output register
  pds_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .u_pos          (u_pos),
    .v_pos          (v_pos),
    .amplitude      (amplitude),
    .half_thickness (half_thickness),
    .done           (done),
    .deflection     (deflection)
  );

`ifndef SYNTH
  // a result beat only ends a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a preceding busy cycle");

  // an accepted start launches the sequence
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start accepted but block not busy");

  // busy drops exactly when the result beat is issued
  a_busy_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result beat");
`endif

endmodule

@@ bench/tb_plate_deflection_series.sv @@
// testbench for the plate deflection series block: directed and random points
`timescale 1ns / 1ps

module tb_plate_deflection_series;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [15:0]        u_pos;
  logic [15:0]        v_pos;
  logic               wr_en;
  logic [1:0]         wr_index;
  logic [31:0]        wr_data;
  logic               done;
  logic signed [33:0] deflection;

  plate_deflection_series uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .u_pos(u_pos), .v_pos(v_pos),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .deflection(deflection)
  );

  // register index with no register behind it
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // one point to evaluate, or a register write between phases
  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] val;
    logic [15:0] u;
    logic [15:0] v;
  } point_t;

  point_t             pending_points[$];
  logic signed [33:0] expected_deflection[$];

  // local copy of the configuration registers
  logic [31:0] amp_reg;
  logic [31:0] offset_reg;
  logic [4:0]  nterms_reg;

  int     errors;
  bit     stim_done;
  logic   accepted;
  int     gap_left;
  point_t pt;
  longint cycle_count;
  localparam longint CYCLE_LIMIT = 30_000_000;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // sine of p*pi*u as sign and Q16 magnitude, Horner polynomial in Q30
  function automatic logic [16:0] harmonic_sine(input longint unsigned p,
                                                input logic [15:0] u,
                                                output bit neg);
    longint unsigned h, r, z, z2, acc, s;
    h = (p * u) & 64'h1FFFF;
    r = h & 64'hFFFF;
    neg = (h >> 16) != 0;
    if (r > 32768) r = 65536 - r;
    z = r << 15;
    z2 = (z * z) >> 30;
    acc = pds_pkg::SIN_C9;
    acc = pds_pkg::SIN_C7 - ((z2 * acc) >> 30);
    acc = pds_pkg::SIN_C5 - ((z2 * acc) >> 30);
    acc = pds_pkg::SIN_C3 - ((z2 * acc) >> 30);
    acc = pds_pkg::SIN_C1 - ((z2 * acc) >> 30);
    s = (z * acc) >> 30;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    s = (s + (64'd1 << (29 - pds_pkg::FRAC_BITS))) >> (30 - pds_pkg::FRAC_BITS);
    if (s == 0) neg = 0;
    return s[16:0];
  endfunction

  function automatic logic signed [33:0] plate_deflection(input logic [15:0] u,
                                                          input logic [15:0] v);
    int unsigned    t;
    longint         sum, res, tv;
    longint unsigned p, q, sp, sq, ss, den, num, mag, prod;
    bit             np, nq, sneg;
    t = nterms_reg;
    if (t < 1) t = 1;
    if (t > pds_pkg::MAX_TERMS) t = pds_pkg::MAX_TERMS;
    sum = 0;
    for (int m = 1; m <= t; m++) begin
      p = 2 * m - 1;
      sp = harmonic_sine(p, u, np);
      for (int n = 1; n <= t; n++) begin
        q = 2 * n - 1;
        sq = harmonic_sine(q, v, nq);
        ss = p * p + q * q;
        den = p * q * ss * ss;
        num = (sp * sq) << (pds_pkg::ACC_BITS - 2 * pds_pkg::FRAC_BITS);
        tv = longint'(num / den);
        sum += (np != nq) ? -tv : tv;
      end
    end
    sneg = sum < 0;
    mag = sneg ? longint'(-sum) : sum;
    mag = (mag + (64'd1 << 15)) >> 16;
    if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
    // full-scale sum: the scaled product is exactly the amplitude
    if (mag == (64'd1 << 32)) prod = amp_reg;
    else prod = (mag * amp_reg + (64'd1 << 31)) >> 32;
    res = sneg ? -longint'(prod) : longint'(prod);
    res += longint'(offset_reg);
    if (res > 64'sd8589934591) res = 64'sd8589934591;
    if (res < -64'sd8589934592) res = -64'sd8589934592;
    return res[33:0];
  endfunction

  // mostly short gaps, now and then a long one, sometimes none for a while
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_point(input logic [15:0] u, input logic [15:0] v);
    point_t item;
    item.is_cfg = 0; item.idx = '0; item.val = '0; item.u = u; item.v = v;
    pending_points = {pending_points, item};
  endtask

  task automatic add_write(input logic [1:0] idx, input logic [31:0] val);
    point_t item;
    item.is_cfg = 1; item.idx = idx; item.val = val; item.u = '0; item.v = '0;
    pending_points = {pending_points, item};
  endtask

  // stimulus: directed corners first, then random phases of settings
  initial begin
    logic [4:0] tc;
    add_write(pds_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
    add_write(pds_pkg::REG_HALF_THICK, 32'h0);
    add_write(pds_pkg::REG_TERM_COUNT, 32'd1);
    add_point(16'h0000, 16'h0000);   // position at zero leaves only the offset
    add_point(16'h8000, 16'h8000);   // plate center, largest deflection
    add_point(16'hFFFF, 16'hFFFF);
    add_point(16'h0001, 16'h8000);
    add_write(pds_pkg::REG_TERM_COUNT, 32'd0); // zero count acts as one harmonic
    add_point(16'h8000, 16'h4000);
    add_point(16'hFFFF, 16'h0001);
    add_write(pds_pkg::REG_TERM_COUNT, 32'd31); // above the maximum, saturates
    add_write(pds_pkg::REG_HALF_THICK, 32'hFFFF_FFFF);
    add_point(16'h8000, 16'h8000);
    add_point(16'h5555, 16'hAAAA);
    add_point(16'h0000, 16'hFFFF);
    add_write(REG_UNMAPPED, 32'h1234_5678);   // unknown index must be ignored
    add_write(pds_pkg::REG_TERM_COUNT, 32'd16);
    add_write(pds_pkg::REG_HALF_THICK, 32'h0);
    add_point(16'h2AAA, 16'hD555);
    add_point(16'h7FFF, 16'h0001);
    add_write(pds_pkg::REG_AMPLITUDE, 32'h0);
    add_point(16'h8000, 16'h8000);
    // random phases; big term counts are rare since they make each point slow
    for (int ph = 0; ph < 25; ph++) begin
      add_write(pds_pkg::REG_AMPLITUDE,
                ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      add_write(pds_pkg::REG_HALF_THICK, ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom);
      tc = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(1, 4));
      add_write(pds_pkg::REG_TERM_COUNT, 32'(tc));
      if ($urandom_range(0, 4) == 0) add_write(REG_UNMAPPED, $urandom);
      for (int i = 0; i < 29; i++) add_point(rand_pos(), rand_pos());
    end
  end

  // driver: one beat or register write at a time, changes on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start = 1'b0; u_pos = '0; v_pos = '0;
      wr_en = 1'b0; wr_index = '0; wr_data = '0;
      gap_left = 0;
      stim_done = 0;
    end else begin
      wr_en = 1'b0;
      if (start) begin
        // hold the beat until the block takes it on a rising edge
        if (accepted) begin
          start = 1'b0;
          u_pos = 16'($urandom); v_pos = 16'($urandom);
          gap_left = gap_len();
        end
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_points.size() > 0) begin
        if (pending_points[0].is_cfg) begin
          // writes only once the block is idle and every result is in
          if (expected_deflection.size() == 0 && !busy) begin
            pt = pending_points.pop_front();
            wr_en = 1'b1; wr_index = pt.idx; wr_data = pt.val;
          end
        end else begin
          pt = pending_points.pop_front();
          start = 1'b1; u_pos = pt.u; v_pos = pt.v;
        end
      end else begin
        stim_done = 1;
      end
    end
  end

  // monitor: register model, expectations at accepted beats, result compare
  always @(posedge clk) begin
    if (rst) begin
      amp_reg    <= '0;
      offset_reg <= '0;
      nterms_reg <= 5'd8;
      accepted   <= 1'b0;
      errors     = 0;
    end else begin
      if (done) begin
        if (expected_deflection.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, deflection);
          errors++;
        end else begin
          if (deflection !== expected_deflection[0]) begin
            $display("%0t: deflection mismatch, expected %0d, actual %0d",
                     $time, expected_deflection[0], deflection);
            errors++;
          end
          void'(expected_deflection.pop_front());
        end
      end
      accepted <= start && !busy;
      if (start && !busy)
        expected_deflection = {expected_deflection, plate_deflection(u_pos, v_pos)};
      if (wr_en) begin
        case (wr_index)
          pds_pkg::REG_AMPLITUDE:  amp_reg    <= wr_data;
          pds_pkg::REG_HALF_THICK: offset_reg <= wr_data;
          pds_pkg::REG_TERM_COUNT: nterms_reg <= wr_data[4:0];
          default: ;
        endcase
      end
    end
  end

  // end of run and cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
      if (stim_done && expected_deflection.size() == 0) begin
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_deflection.size() == 0)
          $display("Verification passed");
        else
          $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
